@@ src/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and constants shared by the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int TABLE_SIZE    = 64;
   localparam int SLOT_BITS     = $clog2(TABLE_SIZE);
   localparam int MAX_KEY_BYTES = 16;
   localparam int VALUE_BITS    = 32;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_MULT  = 32'd16777619;

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_GET    = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_UPDATED   = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_DELETED   = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_state_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH,
      S_READ,
      S_CHECK,
      S_DONE
   } fsm_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key_lo;
      logic [63:0] key_hi;
      logic [4:0]  key_len;
      logic [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value_out;
      logic [5:0]  slot;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic step;
   } hash_ctl_type;

endpackage

@@ src/linear_probe_hash_table.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with FNV-1a home slot and linear probing.
//
//   channel | ports              | handshake
//   request | req_payload        | start & !busy
//   result  | rsp_payload        | rsp_valid, one cycle, no stall
//
// An item is hashed one key byte at a time, then each probe is a registered
// memory read followed by a compare, for at most TABLE_SIZE probes, then a
// done state leads to the registered result strobe.
// Reset empties all slots at once through per-slot status flops.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module linear_probe_hash_table import lpht_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   typedef struct packed {
      logic [63:0]           lo;
      logic [63:0]           hi;
      logic [4:0]            len;
      logic [VALUE_BITS-1:0] value;
   } entry_type;

   entry_type      mem [TABLE_SIZE];
   entry_type      rd_ff;
   slot_state_type stat_ff [TABLE_SIZE];

   fsm_type        state_ff, state_in;
   req_type        req_ff;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic [SLOT_BITS:0]   cnt_ff, cnt_in;
   rsp_type        rsp_ff, rsp_in;
   logic           valid_ff, valid_in;
   logic           wr_en, st_en;
   slot_state_type st_val;
   hash_ctl_type   hctl;
   logic           hdone;
   logic [31:0]    hval;
   logic [4:0]     len_sat;
   logic [63:0]    lo_m, hi_m;
   logic           match;
   slot_state_type cur;

   function automatic logic [63:0] keep(input logic [63:0] w, input logic [4:0] n);
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < 8; i++) begin
         if (5'(i) < n) m[i*8 +: 8] = 8'hFF;
      end
      return w & m;
   endfunction

   assign len_sat = (req_payload.key_len > 5'(MAX_KEY_BYTES)) ? 5'(MAX_KEY_BYTES)
                                                              : req_payload.key_len;

   assign lo_m = req_ff.key_lo;
   assign hi_m = req_ff.key_hi;
   assign cur  = stat_ff[idx_ff];
   assign match = (rd_ff.len == req_ff.key_len) && (rd_ff.lo == lo_m) && (rd_ff.hi == hi_m);

   lpht_hash u_hash (
      .clock   (clock),
      .reset   (reset),
      .ctl     (hctl),
      .key     ({hi_m, lo_m}),
      .key_len (req_ff.key_len),
      .done    (hdone),
      .hash    (hval)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (start) state_in = S_HASH;
         S_HASH:  if (hdone) state_in = S_READ;
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            state_in = S_READ;
            if (func_type'(req_ff.func) == FUNC_INSERT) begin
               if (cur != SLOT_USED || match || cnt_ff == (SLOT_BITS+1)'(TABLE_SIZE - 1))
                  state_in = S_DONE;
            end else if (cur == SLOT_EMPTY || (cur == SLOT_USED && match) ||
                         cnt_ff == (SLOT_BITS+1)'(TABLE_SIZE - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      hctl     = '0;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      rsp_in   = rsp_ff;
      valid_in = 1'b0;
      wr_en    = 1'b0;
      st_en    = 1'b0;
      st_val   = SLOT_USED;
      case (state_ff)
         S_IDLE: begin
            hctl.start = start;
            rsp_in = '{status: ST_NOT_FOUND, value_out: '0, slot: '0};
         end
         S_HASH: begin
            hctl.step = 1'b1;
            idx_in = hval[SLOT_BITS-1:0];
            cnt_in = '0;
         end
         S_CHECK: begin
            idx_in = idx_ff + 1'b1;
            cnt_in = cnt_ff + 1'b1;
            case (func_type'(req_ff.func))
               FUNC_INSERT: begin
                  if (cur != SLOT_USED) begin
                     wr_en = 1'b1; st_en = 1'b1;
                     rsp_in = '{status: ST_INSERTED, value_out: '0, slot: 6'(idx_ff)};
                  end else if (match) begin
                     wr_en = 1'b1;
                     rsp_in = '{status: ST_UPDATED, value_out: '0, slot: 6'(idx_ff)};
                  end else begin
                     rsp_in = '{status: ST_FULL, value_out: '0, slot: '0};
                  end
               end
               FUNC_GET, FUNC_DELETE: begin
                  if (cur == SLOT_USED && match) begin
                     if (func_type'(req_ff.func) == FUNC_GET) begin
                        rsp_in = '{status: ST_FOUND, value_out: 32'(rd_ff.value),
                                   slot: 6'(idx_ff)};
                     end else begin
                        st_en = 1'b1; st_val = SLOT_TOMB;
                        rsp_in = '{status: ST_DELETED, value_out: '0, slot: 6'(idx_ff)};
                     end
                  end
               end
               default: ;
            endcase
         end
         S_DONE: valid_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         for (int i = 0; i < TABLE_SIZE; i++) stat_ff[i] <= SLOT_EMPTY;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (st_en) stat_ff[idx_ff] <= st_val;
      end
      idx_ff <= idx_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
      if (state_ff == S_IDLE && start) begin
         req_ff.func     <= req_payload.func;
         req_ff.key_lo   <= keep(req_payload.key_lo, len_sat);
         req_ff.key_hi   <= keep(req_payload.key_hi, (len_sat > 5'd8) ? len_sat - 5'd8 : 5'd0);
         req_ff.key_len  <= len_sat;
         req_ff.value_in <= req_payload.value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[idx_ff] <= '{lo: lo_m, hi: hi_m, len: req_ff.key_len,
                          value: req_ff.value_in[VALUE_BITS-1:0]};
      end
      rd_ff <= mem[idx_in];
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result while busy");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted start did not raise busy");

endmodule

@@ src/lpht_hash.sv @@
// ----------------------------------------------------------------------------
// lpht_hash
// Byte-serial FNV-1a hash, one key byte per cycle through one multiplier.
// ----------------------------------------------------------------------------
module lpht_hash import lpht_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  hash_ctl_type  ctl,
   input  logic [127:0]  key,
   input  logic [4:0]    key_len,
   output logic          done,
   output logic [31:0]   hash
);

   logic [31:0] hash_ff, hash_in;
   logic [4:0]  idx_ff, idx_in;
   logic [7:0]  byte_v;
   logic [31:0] mix;

   assign byte_v = key[{idx_ff[3:0], 3'b000} +: 8];
   assign mix    = hash_ff ^ {24'd0, byte_v};

   always_comb begin
      hash_in = hash_ff;
      idx_in  = idx_ff;
      if (ctl.start) begin
         hash_in = FNV_BASIS;
         idx_in  = 5'd0;
      end else if (ctl.step && !done) begin
         hash_in = 32'(mix * FNV_MULT);
         idx_in  = idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 5'd0;
      end else begin
         idx_ff <= idx_in;
      end
      hash_ff <= hash_in;
   end

   assign done = (idx_ff >= key_len);
   assign hash = hash_ff;

endmodule

@@ bench/linear_probe_hash_table_tb.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Drives directed and random insert, get and delete transactions into the
// hash table, predicts each result with a behavioral table model, and checks
// every result transaction against the queue of predicted results.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
   import lpht_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_CYCLES = 900000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   slot_state_type tbl_state [TABLE_SIZE];
   logic [63:0]    tbl_lo    [TABLE_SIZE];
   logic [63:0]    tbl_hi    [TABLE_SIZE];
   logic [4:0]     tbl_len   [TABLE_SIZE];
   logic [31:0]    tbl_value [TABLE_SIZE];

   rsp_type pending_rsp [$];
   int      mismatches = 0;
   int      cycles     = 0;
   int      idle_pct   = 0;
   logic [63:0] pool_lo [8];
   logic [63:0] pool_hi [8];
   logic [4:0]  pool_len [8];

   always #2 clock = ~clock;

   linear_probe_hash_table dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   function automatic logic [63:0] mask_bytes(logic [63:0] w, int n);
      if (n >= 8) return w;
      if (n <= 0) return '0;
      return w & ((64'd1 << (8 * n)) - 64'd1);
   endfunction

   function automatic rsp_type table_lookup(req_type r);
      rsp_type     o;
      logic [63:0] lo, hi;
      logic [31:0] h;
      int          ln, idx;
      o = '0;
      o.status = ST_NOT_FOUND;
      ln = (r.key_len > MAX_KEY_BYTES) ? MAX_KEY_BYTES : r.key_len;
      lo = mask_bytes(r.key_lo, ln);
      hi = mask_bytes(r.key_hi, ln - 8);
      h = FNV_BASIS;
      for (int i = 0; i < ln; i++) begin
         h = (h ^ ((i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8])) * FNV_MULT;
      end
      idx = h % TABLE_SIZE;
      if (r.func == FUNC_INSERT) begin
         o.status = ST_FULL;
         for (int n = 0; n < TABLE_SIZE; n++) begin
            if (tbl_state[idx] != SLOT_USED) begin
               tbl_state[idx] = SLOT_USED;
               tbl_lo[idx] = lo;
               tbl_hi[idx] = hi;
               tbl_len[idx] = 5'(ln);
               tbl_value[idx] = r.value_in;
               o.status = ST_INSERTED;
               o.slot = 6'(idx);
               break;
            end
            if (tbl_len[idx] == ln && tbl_lo[idx] == lo && tbl_hi[idx] == hi) begin
               tbl_value[idx] = r.value_in;
               o.status = ST_UPDATED;
               o.slot = 6'(idx);
               break;
            end
            idx = (idx + 1) % TABLE_SIZE;
         end
      end else if (r.func == FUNC_GET || r.func == FUNC_DELETE) begin
         for (int n = 0; n < TABLE_SIZE; n++) begin
            if (tbl_state[idx] == SLOT_EMPTY) break;
            if (tbl_state[idx] == SLOT_USED && tbl_len[idx] == ln &&
                tbl_lo[idx] == lo && tbl_hi[idx] == hi) begin
               if (r.func == FUNC_GET) begin
                  o.status = ST_FOUND;
                  o.value_out = tbl_value[idx];
               end else begin
                  tbl_state[idx] = SLOT_TOMB;
                  o.status = ST_DELETED;
               end
               o.slot = 6'(idx);
               break;
            end
            idx = (idx + 1) % TABLE_SIZE;
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_payload);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.status !== want.status ||
                rsp_payload.value_out !== want.value_out ||
                rsp_payload.slot !== want.slot) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: expected st=%0d val=%h slot=%0d,",
                            " got st=%0d val=%h slot=%0d"},
                           want.status, want.value_out, want.slot,
                           rsp_payload.status, rsp_payload.value_out, rsp_payload.slot);
            end
         end
      end
   end

   // send one transaction; predict at acceptance
   task automatic send(req_type r, bit typed = 0, rsp_type typed_rsp = '0);
      rsp_type p;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      p = table_lookup(r);
      if (typed && p != typed_rsp) begin
         mismatches++;
         if (mismatches <= 10) $display("directed row mismatch for %h", r);
      end
      pending_rsp.push_back(p);
   endtask

   function automatic req_type mk(func_type f, logic [63:0] lo, logic [63:0] hi,
                                  logic [4:0] ln, logic [31:0] v);
      req_type r;
      r.func = f; r.key_lo = lo; r.key_hi = hi; r.key_len = ln; r.value_in = v;
      return r;
   endfunction

   function automatic rsp_type mr(status_type s);
      rsp_type o;
      o = '0;
      o.status = s;
      return o;
   endfunction

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } row_type;

   initial begin
      row_type rows [$];
      req_type r;
      int      k, phase;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         tbl_state[i] = SLOT_EMPTY;
         tbl_lo[i] = '0; tbl_hi[i] = '0; tbl_len[i] = '0; tbl_value[i] = '0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      rows.push_back('{mk(FUNC_GET, '1, '1, 5'd16, 0), 1, mr(ST_NOT_FOUND)});
      rows.push_back('{mk(FUNC_DELETE, '1, '1, 5'd16, 0), 1, mr(ST_NOT_FOUND)});
      rows.push_back('{mk(FUNC_NONE, '1, '1, 5'd31, '1), 1, mr(ST_NOT_FOUND)});
      rows.push_back('{mk(FUNC_INSERT, 0, 0, 5'd0, 32'hFFFF_FFFF), 0, '0});
      rows.push_back('{mk(FUNC_GET, '1, '1, 5'd0, 0), 0, '0});
      rows.push_back('{mk(FUNC_INSERT, '1, '1, 5'd16, 0), 0, '0});
      rows.push_back('{mk(FUNC_GET, '1, '1, 5'd31, 0), 0, '0});
      rows.push_back('{mk(FUNC_INSERT, '1, '1, 5'd31, 32'h1234_5678), 0, '0});
      rows.push_back('{mk(FUNC_INSERT, 64'h55, '1, 5'd1, 1), 0, '0});
      rows.push_back('{mk(FUNC_GET, 64'hAB55, 0, 5'd1, 0), 0, '0});
      rows.push_back('{mk(FUNC_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555, 5'd9, 7), 0, '0});
      rows.push_back('{mk(FUNC_GET, 64'hAAAA_AAAA_AAAA_AAAA, 64'hFF55, 5'd9, 0), 0, '0});
      rows.push_back('{mk(FUNC_DELETE, 64'h55, 0, 5'd1, 0), 0, '0});
      rows.push_back('{mk(FUNC_DELETE, 64'h55, 0, 5'd1, 0), 0, '0});
      rows.push_back('{mk(FUNC_GET, 64'h55, 0, 5'd1, 0), 0, '0});
      rows.push_back('{mk(FUNC_INSERT, 64'h55, 0, 5'd1, 9), 0, '0});
      rows.push_back('{mk(FUNC_DELETE, 0, 0, 5'd0, 0), 0, '0});
      rows.push_back('{mk(FUNC_GET, 0, 0, 5'd0, 0), 0, '0});
      rows.push_back('{mk(FUNC_NONE, 0, 0, 5'd0, 0), 1, mr(ST_NOT_FOUND)});
      foreach (rows[i]) send(rows[i].req, rows[i].typed, rows[i].rsp);

      // random part: keys from a small pool that changes by phase, so the
      // table fills, wraps, reports full and fills with tombstones
      for (int n = 0; n < 1250; n++) begin
         if (n % 125 == 0) begin
            phase = (n / 125) % 4;
            idle_pct = (phase == 1) ? 83 : (phase == 3) ? 11 : 0;
            for (int j = 0; j < 8; j++) begin
               pool_lo[j] = {$urandom, $urandom};
               pool_hi[j] = {$urandom, $urandom};
               pool_len[j] = 5'($urandom_range(20));
            end
         end
         r.key_lo = {$urandom, $urandom};
         r.key_hi = {$urandom, $urandom};
         r.key_len = 5'($urandom_range(31));
         r.value_in = $urandom;
         k = $urandom_range(99);
         if (k < 45) r.func = FUNC_INSERT;
         else if (k < 72) r.func = FUNC_GET;
         else if (k < 97) r.func = FUNC_DELETE;
         else r.func = FUNC_NONE;
         if ($urandom_range(99) < 60) begin
            k = $urandom_range(7);
            r.key_lo = pool_lo[k]; r.key_hi = pool_hi[k]; r.key_len = pool_len[k];
            if ($urandom_range(3) == 0) r.key_hi[63:56] = 8'($urandom);
         end else if ((n / 250) % 2 == 1) begin
            r.key_len = 5'($urandom_range(1, 2));
         end
         send(r);
      end
      start <= 1'b0;

      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
src/lpht_pkg.sv
src/lpht_hash.sv
src/linear_probe_hash_table.sv
bench/linear_probe_hash_table_tb.sv
